// ===== rtl/ipfm_pkg.sv =====
// shared types and codes for the policy first-match unit
package ipfm_pkg;
    typedef enum logic [2:0] {
        K_CLEAR      = 3'd0,
        K_STAGE_POL  = 3'd1,
        K_APPEND     = 3'd2,
        K_STAGE_FLOW = 3'd3,
        K_LOOKUP     = 3'd4
    } t_kind;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_MATCH   = 2'd3;

    localparam logic [1:0] ACT_PROTECT = 2'd2;
    localparam logic [7:0] LEN_V4      = 8'd4;
    localparam logic [7:0] LEN_V6      = 8'd16;

    // one stored policy
    typedef struct packed {
        logic [7:0][63:0] bounds;
        logic [15:0] sp_lo, sp_hi, dp_lo, dp_hi;
        logic [7:0]  len;
        logic [7:0]  proto;
        logic [1:0]  action;
        logic [31:0] spi;
    } t_policy;

    // flow key that walks along the cell row
    typedef struct packed {
        logic [3:0][63:0] addrs;
        logic [7:0]  len;
        logic [7:0]  proto;
        logic [15:0] sport, dport;
    } t_flow;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic        busy;
        logic        hit;
        logic [3:0]  idx;
        logic [1:0]  action;
        logic [31:0] spi;
    } t_token;
endpackage

// ===== rtl/ipfm_cell.sv =====
// one policy cell: holds a policy and checks the passing flow against it
module ipfm_cell import ipfm_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  t_policy          i_pol,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [IDX_W:0]   i_count,
    input  t_flow            i_flow,
    input  t_token           i_tok,
    output t_flow            o_flow,
    output t_token           o_tok
);
    t_policy r_pol;
    t_flow   r_flow;
    t_token  r_tok, n_tok;
    logic    w_match, w_short, w_sl, w_sh, w_dl, w_dh;

    function automatic logic addr_ge(input logic [63:0] ah, input logic [63:0] al,
                                     input logic [63:0] bh, input logic [63:0] bl,
                                     input logic sh);
        if (sh) return ah[63:32] >= bh[63:32];
        return {ah, al} >= {bh, bl};
    endfunction

    always_comb begin
        w_short = (r_pol.len == LEN_V4);
        w_sl = addr_ge(i_flow.addrs[0], i_flow.addrs[1],
                       r_pol.bounds[0], r_pol.bounds[1], w_short);
        w_sh = addr_ge(r_pol.bounds[2], r_pol.bounds[3],
                       i_flow.addrs[0], i_flow.addrs[1], w_short);
        w_dl = addr_ge(i_flow.addrs[2], i_flow.addrs[3],
                       r_pol.bounds[4], r_pol.bounds[5], w_short);
        w_dh = addr_ge(r_pol.bounds[6], r_pol.bounds[7],
                       i_flow.addrs[2], i_flow.addrs[3], w_short);
        w_match = ({1'b0, i_pos} < i_count) && (r_pol.len == i_flow.len)
            && (r_pol.len == LEN_V4 || r_pol.len == LEN_V6)
            && (r_pol.proto == 8'd0 || r_pol.proto == i_flow.proto)
            && w_sl && w_sh && w_dl && w_dh
            && i_flow.sport >= r_pol.sp_lo && i_flow.sport <= r_pol.sp_hi
            && i_flow.dport >= r_pol.dp_lo && i_flow.dport <= r_pol.dp_hi;
        n_tok = i_tok;
        if (i_tok.busy && !i_tok.hit && w_match) begin
            n_tok.hit    = 1'b1;
            n_tok.idx    = 4'(i_pos);
            n_tok.action = r_pol.action;
            n_tok.spi    = r_pol.spi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_pol <= i_pol;
        r_flow <= i_flow;
        if (!i_rst_n) r_tok <= '0;
        else          r_tok <= n_tok;
    end

    assign o_flow = r_flow;
    assign o_tok  = r_tok;
endmodule

// ===== rtl/ipsec_policy_first_match_unit.sv =====
// top level of the ipsec policy first-match unit
// usage:
//   one input channel carries command words (clear, stage policy word, append,
//   stage flow word, lookup); one output channel returns one result word per
//   command. both use valid/ready.
//   the policy table is a row of POLICY_ENTRIES cells. a lookup token enters
//   the first cell and moves one cell per cycle together with the flow key;
//   the first cell whose policy matches marks the token, later cells pass it.
// command flow:
//   a lookup result is set by the walk along the cell row; other commands
//   answer from the result register directly. one command is in flight at a
//   time, and the next word is accepted only after the result is taken.
// reset:
//   policy count, staged bound words and flow words clear; the stored
//   policies are undefined until appended.
// stall:
//   a result sits in the output register until taken; no new word is
//   accepted while it waits.
module ipsec_policy_first_match_unit import ipfm_pkg::*; #(
    parameter int POLICY_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_word_index,
    input  logic [63:0] i_word,
    input  logic [7:0]  i_addr_len,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_src_port_lo,
    input  logic [15:0] i_src_port_hi,
    input  logic [15:0] i_dst_port_lo,
    input  logic [15:0] i_dst_port_hi,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_spi,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_policy_index,
    output logic [1:0]  o_matched_action,
    output logic [31:0] o_matched_spi
);
    localparam int IDX_W = (POLICY_ENTRIES > 1) ? $clog2(POLICY_ENTRIES) : 1;

    logic [IDX_W:0]   r_count;
    logic [7:0][63:0] r_staged;
    logic [3:0][63:0] r_flow_addrs;
    logic             r_busy;     // command in flight or result waiting
    logic             r_out_v;
    logic [1:0]       r_status;
    logic [3:0]       r_idx;
    logic [1:0]       r_act;
    logic [31:0]      r_spi;

    t_flow   flow_c  [POLICY_ENTRIES+1];
    t_token  tok_c   [POLICY_ENTRIES+1];
    t_policy w_pol;
    t_token  w_tok_in;
    logic    w_acc, w_full;

    assign w_acc   = i_valid && o_ready;
    assign o_ready = !r_busy;
    assign w_full  = (r_count >= (IDX_W+1)'(POLICY_ENTRIES));

    // policy word built from staged bounds and the append command
    always_comb begin
        w_pol.bounds = r_staged;
        w_pol.sp_lo  = i_src_port_lo;
        w_pol.sp_hi  = i_src_port_hi;
        w_pol.dp_lo  = i_dst_port_lo;
        w_pol.dp_hi  = i_dst_port_hi;
        w_pol.len    = i_addr_len;
        w_pol.proto  = i_protocol;
        w_pol.action = i_action;
        w_pol.spi    = (i_action == ACT_PROTECT) ? i_spi : 32'd0;
    end

    // flow key and token entering the first cell
    assign flow_c[0] = {r_flow_addrs, i_addr_len, i_protocol, i_src_port_lo, i_dst_port_lo};

    always_comb begin
        w_tok_in      = '0;
        w_tok_in.busy = w_acc && (i_kind == K_LOOKUP);
    end

    assign tok_c[0] = w_tok_in;

    // the cell row
    for (genvar g = 0; g < POLICY_ENTRIES; g++) begin : g_cell
        ipfm_cell #(.IDX_W(IDX_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_acc && i_kind == K_APPEND && !w_full
                      && r_count[IDX_W-1:0] == IDX_W'(g)),
            .i_pol   (w_pol),
            .i_pos   (IDX_W'(g)),
            .i_count (r_count),
            .i_flow  (flow_c[g]),
            .i_tok   (tok_c[g]),
            .o_flow  (flow_c[g+1]),
            .o_tok   (tok_c[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_staged     <= '0;
            r_flow_addrs <= '0;
            r_busy       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                r_out_v <= 1'b0;
                r_busy  <= 1'b0;
            end
            if (w_acc) begin
                r_busy   <= 1'b1;
                // append to a full table is rejected
                r_status <= (i_kind == K_APPEND && w_full) ? ST_FULL : ST_DONE;
                r_idx    <= '0;
                r_act    <= '0;
                r_spi    <= '0;
                r_out_v  <= (i_kind != K_LOOKUP);
                case (i_kind)
                    K_CLEAR:     r_count <= '0;
                    K_STAGE_POL: r_staged[i_word_index] <= i_word;
                    K_APPEND: begin
                        if (!w_full) r_count <= r_count + 1'b1;
                    end
                    K_STAGE_FLOW: begin
                        if (!i_word_index[2]) r_flow_addrs[i_word_index[1:0]] <= i_word;
                    end
                    default: ;
                endcase
            end
            if (tok_c[POLICY_ENTRIES].busy) begin
                r_out_v  <= 1'b1;
                r_status <= tok_c[POLICY_ENTRIES].hit ? ST_MATCH : ST_NOMATCH;
                r_idx    <= tok_c[POLICY_ENTRIES].idx;
                r_act    <= tok_c[POLICY_ENTRIES].action;
                r_spi    <= tok_c[POLICY_ENTRIES].spi;
            end
        end
    end

    assign o_valid          = r_out_v;
    assign o_status         = r_status;
    assign o_policy_index   = r_idx;
    assign o_matched_action = r_act;
    assign o_matched_spi    = r_spi;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (IDX_W+1)'(POLICY_ENTRIES))
        else $error("policy count past table size");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result without command in flight");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("accepted word not tracked");
endmodule
